// ===== hdl/lru_pr_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU page replacement package
// Shared widths, defaults and the structs that pass along the frame chain.
// ----------------------------------------------------------------------------
package lru_pr_pkg;

  localparam int unsigned FRAMES_DEF    = 3;
  localparam int unsigned PAGE_BITS_DEF = 16;

  localparam int unsigned PAGE_W  = 16;  // page number port width
  localparam int unsigned FIDX_W  = 6;   // frame index width (up to 64 frames)
  localparam int unsigned RANK_W  = 6;   // recency rank width
  localparam int unsigned FAULT_W = 32;

  // Scan record: travels one cell per cycle and collects the lookup result.
  typedef struct packed {
    logic              tok;
    logic              hit;
    logic [FIDX_W-1:0] hit_idx;
    logic [RANK_W-1:0] hit_rank;
    logic              empty;
    logic [FIDX_W-1:0] empty_idx;
    logic              vic_any;
    logic [FIDX_W-1:0] vic_idx;
    logic [RANK_W-1:0] vic_rank;
  } rec_t;

  // Update command broadcast to every cell once the scan is done.
  typedef struct packed {
    logic              en;
    logic              hit;
    logic [FIDX_W-1:0] slot;
    logic [RANK_W-1:0] ref_rank;
  } upd_t;

endpackage

// ===== hdl/lru_pr_cell.sv =====
// ----------------------------------------------------------------------------
// LRU frame cell
// Holds one frame (valid, page, rank), merges its entry into the passing scan
// record and applies the broadcast update.
// ----------------------------------------------------------------------------
module lru_pr_cell #(
  parameter int unsigned IDX       = 0,
  parameter int unsigned PAGE_BITS = lru_pr_pkg::PAGE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [PAGE_BITS-1:0] key_i,
  input  lru_pr_pkg::rec_t     rec_i,
  input  logic [PAGE_BITS-1:0] vpage_i,
  input  lru_pr_pkg::upd_t     upd_i,
  output lru_pr_pkg::rec_t     rec_o,
  output logic [PAGE_BITS-1:0] vpage_o
);

  localparam int unsigned FW = lru_pr_pkg::FIDX_W;
  localparam int unsigned RW = lru_pr_pkg::RANK_W;
  localparam logic [FW-1:0] MY_IDX = FW'(IDX);

  logic                 valid_q, valid_d;
  logic [PAGE_BITS-1:0] page_q, page_d;
  logic [RW-1:0]        rank_q, rank_d;
  lru_pr_pkg::rec_t     rec_q, rec_d;
  logic [PAGE_BITS-1:0] vpage_q, vpage_d;

  // merge this frame into the record when the token arrives
  always_comb begin
    rec_d     = rec_q;
    rec_d.tok = 1'b0;
    vpage_d   = vpage_q;
    if (rec_i.tok) begin
      rec_d   = rec_i;
      vpage_d = vpage_i;
      if (valid_q && (page_q == key_i) && !rec_i.hit) begin
        rec_d.hit      = 1'b1;
        rec_d.hit_idx  = MY_IDX;
        rec_d.hit_rank = rank_q;
      end
      if (!valid_q && !rec_i.empty) begin
        rec_d.empty     = 1'b1;
        rec_d.empty_idx = MY_IDX;
      end
      // strict compare: lowest index wins a tie
      if (valid_q && (!rec_i.vic_any || (rank_q > rec_i.vic_rank))) begin
        rec_d.vic_any  = 1'b1;
        rec_d.vic_idx  = MY_IDX;
        rec_d.vic_rank = rank_q;
        vpage_d        = page_q;
      end
    end
  end

  // frame update
  always_comb begin
    valid_d = valid_q;
    page_d  = page_q;
    rank_d  = rank_q;
    if (upd_i.en) begin
      if (upd_i.slot == MY_IDX) begin
        valid_d = 1'b1;
        rank_d  = '0;
        if (!upd_i.hit) begin
          page_d = key_i;
        end
      end else if (valid_q && (!upd_i.hit || (rank_q < upd_i.ref_rank))) begin
        rank_d = rank_q + RW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rank_q  <= '0;
      rec_q   <= '0;
    end else begin
      valid_q <= valid_d;
      rank_q  <= rank_d;
      rec_q   <= rec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q  <= page_d;
    vpage_q <= vpage_d;
  end

  assign rec_o   = rec_q;
  assign vpage_o = vpage_q;

endmodule

// ===== hdl/lru_page_replacement.sv =====
// ----------------------------------------------------------------------------
// LRU page replacement
// Fully associative frame set with exact-rank least-recently-used eviction.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid_i / in_ready_o) carries one page reference word.
//    Only the low PAGE_BITS bits of page_number_i are looked up.
//  - Output channel (out_valid_o / out_ready_i) returns one result word per
//    reference: hit flag, frame now holding the page, evicted page (zero
//    when nothing was evicted) and the saturating fault count.
//  - The scan record walks the row of frame cells one cell per cycle, the
//    control sees the token leave the last cell, and then the update step
//    applies the update. Ready returns only after the update, so a new
//    reference is not taken while the previous one is still being scanned
//    or updated.
//  - The result sits in an output register; a new reference is taken while
//    it waits. If the receiver stalls, the next reference finishes its scan
//    and holds in the update step until the output register is free.
//  - Reset empties every frame, clears ranks and the fault counter; the
//    block is ready for a reference straight out of reset.
// ----------------------------------------------------------------------------
module lru_page_replacement #(
  parameter int unsigned FRAMES    = lru_pr_pkg::FRAMES_DEF,
  parameter int unsigned PAGE_BITS = lru_pr_pkg::PAGE_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [lru_pr_pkg::PAGE_W-1:0]      page_number_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               hit_o,
  output logic [lru_pr_pkg::FIDX_W-1:0]      frame_index_o,
  output logic                               evicted_valid_o,
  output logic [lru_pr_pkg::PAGE_W-1:0]      evicted_page_o,
  output logic [lru_pr_pkg::FAULT_W-1:0]     fault_count_o
);

  localparam int unsigned PW = lru_pr_pkg::PAGE_W;
  localparam int unsigned FW = lru_pr_pkg::FIDX_W;
  localparam int unsigned CW = lru_pr_pkg::FAULT_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_UPD  = 3'b100
  } state_e;

  state_e               state_q, state_d;
  logic                 start_q;
  logic [PAGE_BITS-1:0] key_q, key_d;
  logic [CW-1:0]        faults_q, faults_d;

  lru_pr_pkg::rec_t     rec_w   [FRAMES+1];
  logic [PAGE_BITS-1:0] vpage_w [FRAMES+1];
  logic [FRAMES-1:0]    tok_vec;
  lru_pr_pkg::upd_t     upd;
  lru_pr_pkg::rec_t     fin;

  logic                 accept;
  logic                 out_free;
  logic                 commit;
  logic                 miss;
  logic                 evict;
  logic [FW-1:0]        slot;
  logic [PW-1:0]        vpage_ext;

  // output word register
  logic                 out_valid_q;
  logic                 hit_q;
  logic [FW-1:0]        frame_index_q;
  logic                 evicted_valid_q;
  logic [PW-1:0]        evicted_page_q;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign commit     = (state_q == S_UPD) && out_free;

  // key: low PAGE_BITS of the port, zero-extended when wider than the port
  for (genvar b = 0; b < PAGE_BITS; b++) begin : g_key
    if (b < PW) begin : g_in
      assign key_d[b] = page_number_i[b];
    end else begin : g_zero
      assign key_d[b] = 1'b0;
    end
  end

  // head of the chain: token only, empty record
  assign rec_w[0]   = '{tok: start_q, default: '0};
  assign vpage_w[0] = '0;

  for (genvar i = 0; i < FRAMES; i++) begin : g_cell
    lru_pr_cell #(
      .IDX       (i),
      .PAGE_BITS (PAGE_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .key_i   (key_q),
      .rec_i   (rec_w[i]),
      .vpage_i (vpage_w[i]),
      .upd_i   (upd),
      .rec_o   (rec_w[i+1]),
      .vpage_o (vpage_w[i+1])
    );
    assign tok_vec[i] = rec_w[i+1].tok;
  end

  // final record stays in the last cell until the next scan
  assign fin   = rec_w[FRAMES];
  assign miss  = !fin.hit;
  assign evict = miss && !fin.empty;

  always_comb begin
    if (fin.hit) begin
      slot = fin.hit_idx;
    end else if (fin.empty) begin
      slot = fin.empty_idx;
    end else begin
      slot = fin.vic_idx;
    end
  end

  always_comb begin
    upd.en       = commit;
    upd.hit      = fin.hit;
    upd.slot     = slot;
    upd.ref_rank = fin.hit_rank;
  end

  for (genvar b = 0; b < PW; b++) begin : g_vpage
    if (b < PAGE_BITS) begin : g_in
      assign vpage_ext[b] = vpage_w[FRAMES][b];
    end else begin : g_zero
      assign vpage_ext[b] = 1'b0;
    end
  end

  // saturating fault counter
  always_comb begin
    faults_d = faults_q;
    if (commit && miss && (faults_q != {CW{1'b1}})) begin
      faults_d = faults_q + CW'(1);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (tok_vec[FRAMES-1]) begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      start_q     <= 1'b0;
      faults_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      start_q  <= accept;
      faults_q <= faults_d;
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q <= key_d;
    end
    if (commit) begin
      hit_q           <= fin.hit;
      frame_index_q   <= slot;
      evicted_valid_q <= evict;
      evicted_page_q  <= evict ? vpage_ext : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = hit_q;
  assign frame_index_o   = frame_index_q;
  assign evicted_valid_o = evicted_valid_q;
  assign evicted_page_o  = evicted_page_q;
  assign fault_count_o   = faults_q;

`ifndef SYNTHESIS
  // at most one scan token in the chain
  a_tok_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vec))
    else $error("more than one scan token in the frame chain");

  // fault count never goes down
  a_faults_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> faults_q >= $past(faults_q))
    else $error("fault counter decreased");

  // a hit never reports an eviction
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> !evicted_valid_o)
    else $error("eviction reported on a hit");

  // an accepted word always starts a scan
  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_SCAN) && start_q)
    else $error("accepted word did not start a scan");
`endif

endmodule
